// ----- rtl/tpt_pkg.sv -----
package tpt_pkg;

  localparam int TableDepth = 32;
  localparam int IdxW = $clog2(TableDepth);
  localparam int QueueDepth = 2;

  typedef enum logic [2:0] {
    CMD_INIT   = 3'd0,
    CMD_ACK    = 3'd1,
    CMD_FIND   = 3'd2,
    CMD_ISCLI  = 3'd3,
    CMD_REMOVE = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    RES_OK   = 2'd0,
    RES_MISS = 2'd1,
    RES_FULL = 2'd2
  } res_t;

  typedef struct packed {
    logic [15:0] sock;
    logic [15:0] tag;
    logic [15:0] port;
  } side_t;

  typedef struct packed {
    logic [31:0] id;
    side_t       adm;
    side_t       cln;
    logic [7:0]  status;
  } entry_t;

  // classified command travelling from front to back
  typedef struct packed {
    logic        is_init;
    logic        is_ack;
    logic        is_find;
    logic        is_iscli;
    logic        is_remove;
    side_t       adm;
    side_t       cln;
    logic [31:0] tunnel_id;
    logic [7:0]  new_status;
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_DONE
  } bk_state_t;

endpackage

// ----- rtl/tpt_front.sv -----
module tpt_front
  import tpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_command,
  input  logic [15:0] in_socket_a,
  input  logic [15:0] in_tag_a,
  input  logic [15:0] in_port_a,
  input  logic [15:0] in_socket_b,
  input  logic [15:0] in_tag_b,
  input  logic [15:0] in_port_b,
  input  logic [31:0] in_tunnel_id,
  input  logic [7:0]  in_new_status,
  output logic        op_valid,
  output op_t         op,
  input  logic        op_pop
);

  localparam int QW = $clog2(QueueDepth);

  op_t            q_r [QueueDepth];
  logic [QW-1:0]  wp_r, rp_r;
  logic [QW:0]    cnt_r;
  op_t            cls;
  logic           push;

  always_comb begin
    cls           = '0;
    cls.is_init   = (in_command == CMD_INIT);
    cls.is_ack    = (in_command == CMD_ACK);
    cls.is_find   = (in_command == CMD_FIND);
    cls.is_iscli  = (in_command == CMD_ISCLI);
    cls.is_remove = (in_command == CMD_REMOVE);
    cls.adm       = '{sock: in_socket_a, tag: in_tag_a, port: in_port_a};
    cls.cln       = '{sock: in_socket_b, tag: in_tag_b, port: in_port_b};
    cls.tunnel_id = in_tunnel_id;
    cls.new_status = in_new_status;
  end

  assign busy     = (cnt_r == QW'(0) + (QW+1)'(QueueDepth));
  assign push     = start && !busy;
  assign op_valid = (cnt_r != '0);
  assign op       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= cls;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= QW'(wp_r + 1'b1);
      if (op_pop) rp_r <= QW'(rp_r + 1'b1);
      cnt_r <= cnt_r + (QW+1)'(push) - (QW+1)'(op_pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r < (QW+1)'(QueueDepth)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    op_pop |-> op_valid) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QW+1)'(QueueDepth)) else $error("queue count out of range");
`endif

endmodule

// ----- rtl/tpt_back.sv -----
module tpt_back
  import tpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        op_valid,
  input  op_t         op,
  output logic        op_pop,
  output logic        done,
  output logic [1:0]  out_result_code,
  output logic [31:0] out_id,
  output logic [15:0] out_adm_socket,
  output logic [15:0] out_adm_tag,
  output logic [15:0] out_adm_port,
  output logic [15:0] out_cln_socket,
  output logic [15:0] out_cln_tag,
  output logic [15:0] out_cln_port,
  output logic [7:0]  out_status,
  output logic [15:0] out_peer_socket,
  output logic [15:0] out_peer_tag
);

  bk_state_t state_r, state_nxt;

  entry_t          ent_r [TableDepth];
  logic [TableDepth-1:0] vld_r;
  logic [31:0]     idc_r;
  op_t             cur_r;

  // registered match vectors from the first cycle
  logic [TableDepth-1:0] m_adm_r, m_cln_r, m_id_r, m_ctag_r;
  logic [TableDepth-1:0] m_adm, m_cln, m_id, m_ctag;

  always_comb begin
    for (int k = 0; k < TableDepth; k++) begin
      m_adm[k]  = vld_r[k] && ent_r[k].adm.sock == op.adm.sock
                  && ent_r[k].adm.tag == op.adm.tag;
      m_cln[k]  = vld_r[k] && ent_r[k].cln.sock == op.adm.sock
                  && ent_r[k].cln.tag == op.adm.tag;
      m_id[k]   = vld_r[k] && ent_r[k].id == op.tunnel_id;
      m_ctag[k] = vld_r[k] && ent_r[k].cln.tag == op.adm.tag;
    end
  end

  // newest-first priority pick over a hit vector
  logic [TableDepth-1:0] hit;
  logic                  any_hit;
  logic [IdxW-1:0]       sel;

  always_comb begin
    priority if (cur_r.is_ack) hit = m_id_r;
    else if (cur_r.is_iscli)   hit = m_ctag_r;
    else                       hit = m_adm_r | m_cln_r;
    any_hit = |hit;
    sel = '0;
    for (int k = TableDepth - 1; k >= 0; k--) begin
      if (hit[k]) sel = IdxW'(k);
    end
  end

  entry_t se;
  assign se = ent_r[sel];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (op_valid) state_nxt = BK_EXEC;
      BK_EXEC: state_nxt = BK_DONE;
      BK_DONE: state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    op_pop = (state_r == BK_IDLE) && op_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      cur_r    <= op;
      m_adm_r  <= m_adm;
      m_cln_r  <= m_cln;
      m_id_r   <= m_id;
      m_ctag_r <= m_ctag;
    end
  end

  logic full;
  logic exec;
  assign full = vld_r[TableDepth-1];
  assign exec = (state_r == BK_EXEC);

  // table update
  always_ff @(posedge clk) begin
    if (exec) begin
      if (cur_r.is_init && !full) begin
        for (int k = TableDepth - 1; k > 0; k--) ent_r[k] <= ent_r[k-1];
        ent_r[0] <= '{id: idc_r + 32'd1, adm: cur_r.adm, cln: cur_r.cln, status: 8'd0};
      end else if (cur_r.is_ack && any_hit) begin
        ent_r[sel].status <= cur_r.new_status;
      end else if (cur_r.is_remove && any_hit) begin
        for (int k = 0; k < TableDepth - 1; k++) begin
          if (IdxW'(k) >= sel) ent_r[k] <= ent_r[k+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      idc_r <= '0;
    end else if (exec) begin
      if (cur_r.is_init && !full) begin
        vld_r <= {vld_r[TableDepth-2:0], 1'b1};
        idc_r <= idc_r + 32'd1;
      end else if (cur_r.is_remove && any_hit) begin
        vld_r <= {1'b0, vld_r[TableDepth-1:1]};
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (exec) begin
      out_result_code <= RES_MISS;
      out_id          <= '0;
      out_adm_socket  <= '0;
      out_adm_tag     <= '0;
      out_adm_port    <= '0;
      out_cln_socket  <= '0;
      out_cln_tag     <= '0;
      out_cln_port    <= '0;
      out_status      <= '0;
      out_peer_socket <= '0;
      out_peer_tag    <= '0;
      if (cur_r.is_init) begin
        if (full) out_result_code <= RES_FULL;
        else begin
          out_result_code <= RES_OK;
          out_id          <= idc_r + 32'd1;
        end
      end else if (any_hit && (cur_r.is_ack || cur_r.is_remove)) begin
        out_result_code <= RES_OK;
        out_id          <= se.id;
        out_adm_socket  <= se.adm.sock;
        out_adm_tag     <= se.adm.tag;
        out_adm_port    <= se.adm.port;
        out_cln_socket  <= se.cln.sock;
        out_cln_tag     <= se.cln.tag;
        out_cln_port    <= se.cln.port;
        out_status      <= cur_r.is_ack ? cur_r.new_status : se.status;
      end else if (any_hit && cur_r.is_find) begin
        out_result_code <= RES_OK;
        // admin side match wins within one entry
        if (m_adm_r[sel]) begin
          out_peer_socket <= se.cln.sock;
          out_peer_tag    <= se.cln.tag;
        end else begin
          out_peer_socket <= se.adm.sock;
          out_peer_tag    <= se.adm.tag;
        end
      end else if (any_hit && cur_r.is_iscli) begin
        out_result_code <= RES_OK;
      end
    end
  end

  assign done = (state_r == BK_DONE);

`ifndef NO_ASSERTIONS
  a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> $past(exec)) else $error("result without execute");
  a_exec_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    op_pop |=> exec) else $error("pop not followed by execute");
  a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((vld_r + 1'b1) & vld_r) == '0) else $error("valid bits not contiguous");
`endif

endmodule

// ----- rtl/tunnel_pair_table.sv -----
// Tunnel pair table: 32 entries kept newest first. Assert start with a command
// while busy is low; the transfer is taken on that edge. Each command yields
// one result, shown for one cycle with out_valid high; the receiver cannot
// stall it. The execution side handles one command at a time, in order: dequeue
// with a parallel match over all entries, execute/shift, present result; it
// dequeues the next command only after presenting the result, and a two-deep
// command queue lets start be taken while earlier commands still execute.
module tunnel_pair_table
  import tpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_command,
  input  logic [15:0] in_socket_a,
  input  logic [15:0] in_tag_a,
  input  logic [15:0] in_port_a,
  input  logic [15:0] in_socket_b,
  input  logic [15:0] in_tag_b,
  input  logic [15:0] in_port_b,
  input  logic [31:0] in_tunnel_id,
  input  logic [7:0]  in_new_status,
  output logic        out_valid,
  output logic [1:0]  out_result_code,
  output logic [31:0] out_id,
  output logic [15:0] out_adm_socket,
  output logic [15:0] out_adm_tag,
  output logic [15:0] out_adm_port,
  output logic [15:0] out_cln_socket,
  output logic [15:0] out_cln_tag,
  output logic [15:0] out_cln_port,
  output logic [7:0]  out_status,
  output logic [15:0] out_peer_socket,
  output logic [15:0] out_peer_tag
);

  logic op_valid, op_pop;
  op_t  op;

  tpt_front u_front (
    .clk, .rst_n, .start, .busy,
    .in_command, .in_socket_a, .in_tag_a, .in_port_a,
    .in_socket_b, .in_tag_b, .in_port_b, .in_tunnel_id, .in_new_status,
    .op_valid, .op, .op_pop
  );

  tpt_back u_back (
    .clk, .rst_n, .op_valid, .op, .op_pop,
    .done(out_valid),
    .out_result_code, .out_id,
    .out_adm_socket, .out_adm_tag, .out_adm_port,
    .out_cln_socket, .out_cln_tag, .out_cln_port,
    .out_status, .out_peer_socket, .out_peer_tag
  );

endmodule

// ----- test/tunnel_pair_checker.sv -----
module tunnel_pair_checker
  import tpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_command,
  input  logic [15:0] in_socket_a,
  input  logic [15:0] in_tag_a,
  input  logic [15:0] in_port_a,
  input  logic [15:0] in_socket_b,
  input  logic [15:0] in_tag_b,
  input  logic [15:0] in_port_b,
  input  logic [31:0] in_tunnel_id,
  input  logic [7:0]  in_new_status,
  input  logic        out_valid,
  input  logic [1:0]  out_result_code,
  input  logic [31:0] out_id,
  input  logic [15:0] out_adm_socket,
  input  logic [15:0] out_adm_tag,
  input  logic [15:0] out_adm_port,
  input  logic [15:0] out_cln_socket,
  input  logic [15:0] out_cln_tag,
  input  logic [15:0] out_cln_port,
  input  logic [7:0]  out_status,
  input  logic [15:0] out_peer_socket,
  input  logic [15:0] out_peer_tag,
  output int          fail_count,
  output int          pending,
  output int          live_entries
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  code;
    logic [31:0] id;
    side_t       adm;
    side_t       cln;
    logic [7:0]  status;
    logic [15:0] psock;
    logic [15:0] ptag;
  } reply_t;

  entry_t      tbl[$];
  logic [31:0] next_id;
  reply_t      replies[$];

  assign pending = replies.size();
  assign live_entries = tbl.size();

  function automatic reply_t run_command(input logic [2:0] cmd, input side_t a, input side_t b,
                                         input logic [31:0] tid, input logic [7:0] st);
    reply_t r;
    entry_t e;
    r = '0;
    r.code = RES_MISS;
    case (cmd)
      CMD_INIT: begin
        if (tbl.size() == TableDepth) r.code = RES_FULL;
        else begin
          next_id = next_id + 1;
          e.id = next_id;
          e.adm = a;
          e.cln = b;
          e.status = '0;
          // newest entry goes to index 0
          tbl.insert(0, e);
          r.code = RES_OK;
          r.id = next_id;
        end
      end
      CMD_ACK: begin
        foreach (tbl[i]) if (tbl[i].id == tid) begin
          tbl[i].status = st;
          r.code = RES_OK;
          r.id = tbl[i].id; r.adm = tbl[i].adm; r.cln = tbl[i].cln; r.status = st;
          break;
        end
      end
      CMD_FIND: begin
        foreach (tbl[i]) begin
          if (tbl[i].adm.sock == a.sock && tbl[i].adm.tag == a.tag) begin
            r.code = RES_OK; r.psock = tbl[i].cln.sock; r.ptag = tbl[i].cln.tag;
            break;
          end
          if (tbl[i].cln.sock == a.sock && tbl[i].cln.tag == a.tag) begin
            r.code = RES_OK; r.psock = tbl[i].adm.sock; r.ptag = tbl[i].adm.tag;
            break;
          end
        end
      end
      CMD_ISCLI: begin
        foreach (tbl[i]) if (tbl[i].cln.tag == a.tag) begin
          r.code = RES_OK;
          break;
        end
      end
      CMD_REMOVE: begin
        foreach (tbl[i]) if ((tbl[i].adm.sock == a.sock && tbl[i].adm.tag == a.tag) ||
                             (tbl[i].cln.sock == a.sock && tbl[i].cln.tag == a.tag)) begin
          r.code = RES_OK;
          r.id = tbl[i].id; r.adm = tbl[i].adm; r.cln = tbl[i].cln; r.status = tbl[i].status;
          tbl.delete(i);
          break;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic compare(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    next_id = '0;
  end

  always @(posedge clk) begin
    reply_t e;
    if (rst_n && out_valid) begin
      if (replies.size() == 0) begin
        $error("result with no command pending");
        fail_count++;
      end else begin
        e = replies.pop_front();
        compare("result_code", e.code, out_result_code);
        compare("out_id", e.id, out_id);
        compare("out_adm_socket", e.adm.sock, out_adm_socket);
        compare("out_adm_tag", e.adm.tag, out_adm_tag);
        compare("out_adm_port", e.adm.port, out_adm_port);
        compare("out_cln_socket", e.cln.sock, out_cln_socket);
        compare("out_cln_tag", e.cln.tag, out_cln_tag);
        compare("out_cln_port", e.cln.port, out_cln_port);
        compare("out_status", e.status, out_status);
        compare("peer_socket", e.psock, out_peer_socket);
        compare("peer_tag", e.ptag, out_peer_tag);
      end
    end
    if (rst_n && start && !busy)
      replies.push_back(run_command(in_command, {in_socket_a, in_tag_a, in_port_a},
                                    {in_socket_b, in_tag_b, in_port_b},
                                    in_tunnel_id, in_new_status));
  end
endmodule

// ----- test/tb_tunnel_pair_table.sv -----
module tb_tunnel_pair_table;
  import tpt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [2:0]  in_command = '0;
  logic [15:0] in_socket_a = '0, in_tag_a = '0, in_port_a = '0;
  logic [15:0] in_socket_b = '0, in_tag_b = '0, in_port_b = '0;
  logic [31:0] in_tunnel_id = '0;
  logic [7:0]  in_new_status = '0;
  logic        out_valid;
  logic [1:0]  out_result_code;
  logic [31:0] out_id;
  logic [15:0] out_adm_socket, out_adm_tag, out_adm_port;
  logic [15:0] out_cln_socket, out_cln_tag, out_cln_port;
  logic [7:0]  out_status;
  logic [15:0] out_peer_socket, out_peer_tag;
  int          fail_count, pending, live_entries;

  // recent entries, reused so lookups and removes mostly hit
  logic [15:0] known_sock[$], known_tag[$];
  logic [31:0] issued;
  bit          calm;

  always #2 clk = ~clk;

  tunnel_pair_table dut (.*);
  tunnel_pair_checker chk (.*);

  task automatic send(input logic [2:0] cmd, input logic [15:0] sa, input logic [15:0] ta,
                      input logic [15:0] pa, input logic [15:0] sb, input logic [15:0] tb,
                      input logic [15:0] pb, input logic [31:0] tid, input logic [7:0] st);
    while (!calm && $urandom_range(99) < 38) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_socket_a <= sa; in_tag_a <= ta; in_port_a <= pa;
    in_socket_b <= sb; in_tag_b <= tb; in_port_b <= pb;
    in_tunnel_id <= tid; in_new_status <= st;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (cmd == CMD_INIT) issued = issued + 1;
  endtask

  task automatic random_item();
    int k, pick, n;
    logic [15:0] s, t;
    k = $urandom_range(99);
    n = known_sock.size();
    pick = n ? $urandom_range(n - 1) : 0;
    s = n ? known_sock[pick] : 16'($urandom);
    t = n ? known_tag[pick] : 16'($urandom);
    if (k < 8) begin
      s = 16'($urandom);
      t = 16'($urandom);
    end
    if (k < 35 || n == 0) begin
      s = 16'($urandom_range(15)); t = 16'($urandom_range(15));
      known_sock.push_back(s); known_tag.push_back(t);
      known_sock.push_back(16'($urandom_range(15))); known_tag.push_back(16'($urandom_range(15)));
      if (known_sock.size() > 40) begin
        void'(known_sock.pop_front()); void'(known_tag.pop_front());
      end
      send(CMD_INIT, s, t, 16'($urandom), known_sock[$], known_tag[$], 16'($urandom),
           32'($urandom), 8'($urandom));
    end else if (k < 50)
      send(CMD_ACK, s, t, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
           (k & 1) ? issued - $urandom_range(40) : 32'($urandom), 8'($urandom));
    else if (k < 68)
      send(CMD_FIND, s, t, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
           32'($urandom), 8'($urandom));
    else if (k < 78)
      send(CMD_ISCLI, s, t, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
           32'($urandom), 8'($urandom));
    else if (k < 96)
      send(CMD_REMOVE, s, t, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
           32'($urandom), 8'($urandom));
    else
      send(3'($urandom_range(7, 5)), s, t, 16'($urandom), 16'($urandom), 16'($urandom),
           16'($urandom), 32'($urandom), 8'($urandom));
  endtask

  initial begin
    int drain;
    issued = 0;
    calm = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: misses on empty table, extremes, full table, each command
    send(CMD_ACK, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 32'd1, 8'hff);
    send(CMD_FIND, 16'hffff, 16'hffff, 16'h0, 16'h0, 16'h0, 16'h0, 32'd0, 8'h0);
    send(CMD_REMOVE, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 32'd0, 8'h0);
    send(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 32'hffffffff, 8'hff);
    send(CMD_INIT, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 32'hffffffff,
         8'hff);
    send(CMD_INIT, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 32'd0, 8'h0);
    send(CMD_INIT, 16'h1, 16'h2, 16'h3, 16'h1, 16'h2, 16'h4, 32'd0, 8'h0);
    send(CMD_FIND, 16'h1, 16'h2, 16'h0, 16'h0, 16'h0, 16'h0, 32'd0, 8'h0);
    send(CMD_FIND, 16'hffff, 16'hffff, 16'h0, 16'h0, 16'h0, 16'h0, 32'd0, 8'h0);
    send(CMD_ISCLI, 16'h0, 16'hffff, 16'h0, 16'h0, 16'h0, 16'h0, 32'd0, 8'h0);
    send(CMD_ISCLI, 16'h0, 16'h1234, 16'h0, 16'h0, 16'h0, 16'h0, 32'd0, 8'h0);
    send(CMD_ACK, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 32'd2, 8'hff);
    send(CMD_ACK, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 32'd99, 8'h55);
    send(CMD_REMOVE, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 32'd0, 8'h0);
    send(3'd5, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 32'd0, 8'h0);
    while (live_entries < TableDepth)
      send(CMD_INIT, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
           16'($urandom), 16'($urandom), 32'd0, 8'h0);
    send(CMD_INIT, 16'h1, 16'h1, 16'h1, 16'h1, 16'h1, 16'h1, 32'd0, 8'h0);
    send(CMD_REMOVE, 16'h1, 16'h2, 16'h0, 16'h0, 16'h0, 16'h0, 32'd0, 8'h0);
    // hold until every result has come back
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    for (int i = 0; i < 900; i++) begin
      calm = (i >= 300 && i < 420);
      random_item();
      if (i == 600) begin
        start <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
    end
    start <= 1'b0;
    drain = 0;
    while (pending != 0 && drain < 1000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("** tunnel_pair_table: PASSED **");
    else
      $display("** tunnel_pair_table: FAILED **");
    $finish;
  end

  initial begin
    #2ms;
    $display("** tunnel_pair_table: FAILED **");
    $finish;
  end
endmodule
